FILE: src/blinn_phong_point_shader_top_macros.svh
// Assertion macros shared by the shader RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef BLINN_PHONG_POINT_SHADER_TOP_MACROS_SVH
`define BLINN_PHONG_POINT_SHADER_TOP_MACROS_SVH

// Condition and consequence in the same cycle.
`define BPS_ASSERT_SAME(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("shader assertion failed");

// Consequence in the cycle after the condition.
`define BPS_ASSERT_NEXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("shader assertion failed");

`endif

FILE: src/bps_pkg.sv
// Constants and register codes for the Blinn-Phong point shader.
// Used by every module of the block but bps_delay; depends on nothing.
package bps_pkg;
	localparam int COORD_WIDTH_DEF = 21;
	localparam int COLOR_FRAC_DEF = 15;
	localparam int NORM_FRAC = 14;
	localparam int NORM_W = NORM_FRAC + 2;
	localparam int NORM_TOP_BIT = 20;
	localparam int NM_W = NORM_TOP_BIT + 1;
	localparam int SQ_W = 2 * NM_W + 2;
	localparam int SQRT_STEPS = SQ_W / 2;
	localparam int ROOT_W = SQRT_STEPS;
	localparam int DIV_STEPS = NORM_FRAC + 1;
	localparam int NUM_W = NM_W + NORM_FRAC;
	localparam int DSOR_W = ROOT_W + NORM_FRAC;
	localparam int NORM_LAT = 8 + SQRT_STEPS + DIV_STEPS;
	localparam int DOT_LAT = 2;
	localparam int SHIN_W = 8;
	localparam int POW_LAT = SHIN_W;
	localparam int SHIN_RESET = 16;
	localparam int DATA_W = 64;
	localparam int ADDR_W = 6;
	localparam int IDX_W = 3;

	// Register indexes on the configuration port.
	localparam logic [IDX_W-1:0] REG_LIGHT_POS = 3'd0;
	localparam logic [IDX_W-1:0] REG_VIEW_POS = 3'd1;
	localparam logic [IDX_W-1:0] REG_LIGHT_COL = 3'd2;
	localparam logic [IDX_W-1:0] REG_LIGHT_AMB = 3'd3;
	localparam logic [IDX_W-1:0] REG_LIGHT_DIFF = 3'd4;
	localparam logic [IDX_W-1:0] REG_LIGHT_SPEC = 3'd5;
	localparam logic [IDX_W-1:0] REG_SHININESS = 3'd6;
endpackage

FILE: src/bps_delay.sv
// Enabled delay line for side data that travels beside the arithmetic.
// Depends on nothing.
module bps_delay #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);
	logic [W-1:0] tap_s [N];

	// Shift one place whenever the pipeline moves.
	always_ff @(posedge clk) begin
		if (en) begin
			tap_s[0] <= din;
			for (int k = 1; k < N; k++) begin
				tap_s[k] <= tap_s[k-1];
			end
		end
	end

	assign dout = tap_s[N-1];
endmodule

FILE: src/bps_norm.sv
// Pipelined vector normaliser: magnitude, range shift, bit-serial square root
// and restoring division, one step per stage. Depends on bps_pkg.
module bps_norm #(
	parameter int IN_W = 22
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [IN_W-1:0]              d [3],
	output logic signed [bps_pkg::NORM_W-1:0]   u [3],
	output logic                                zero
);
	import bps_pkg::*;

	localparam int MAG_W = IN_W;
	localparam int POS_W = $clog2(MAG_W);
	localparam int SH_W = $clog2(MAG_W + NM_W);

	logic             neg_s1 [3];
	logic [MAG_W-1:0] mag_s1 [3];
	logic             neg_s2 [3];
	logic [MAG_W-1:0] mag_s2 [3];
	logic [MAG_W-1:0] top_s2;
	logic             neg_s3 [3];
	logic [MAG_W-1:0] mag_s3 [3];
	logic [POS_W-1:0] pos_s3;
	logic             zero_s3;
	logic             neg_s4 [3];
	logic [NM_W-1:0]  m_s4 [3];
	logic             zero_s4;
	logic             neg_s5 [3];
	logic [NM_W-1:0]  m_s5 [3];
	logic [2*NM_W-1:0] sq_s5 [3];
	logic             zero_s5;

	logic [MAG_W-1:0] top_nx;
	logic [NM_W-1:0]  m_nx [3];

	logic [SQ_W-1:0]  rt_rem_s [SQRT_STEPS+1];
	logic [SQ_W-1:0]  rt_res_s [SQRT_STEPS+1];
	logic [NM_W-1:0]  rt_m_s [SQRT_STEPS+1][3];
	logic             rt_neg_s [SQRT_STEPS+1][3];
	logic             rt_zero_s [SQRT_STEPS+1];
	logic [SQ_W-1:0]  rt_rem_nx [SQRT_STEPS];
	logic [SQ_W-1:0]  rt_res_nx [SQRT_STEPS];

	logic [NUM_W-1:0]     dv_rem_s [DIV_STEPS+1][3];
	logic [DIV_STEPS-1:0] dv_q_s [DIV_STEPS+1][3];
	logic [ROOT_W-1:0]    dv_len_s [DIV_STEPS+1];
	logic                 dv_neg_s [DIV_STEPS+1][3];
	logic                 dv_zero_s [DIV_STEPS+1];
	logic [NUM_W-1:0]     dv_rem_nx [DIV_STEPS][3];
	logic [DIV_STEPS-1:0] dv_q_nx [DIV_STEPS][3];

	// Position of the highest set bit.
	function automatic logic [POS_W-1:0] msb_pos(input logic [MAG_W-1:0] v);
		logic [POS_W-1:0] p;
		p = '0;
		for (int b = 0; b < MAG_W; b++) begin
			if (v[b]) p = POS_W'(b);
		end
		return p;
	endfunction

	// Largest magnitude and range shift.
	always_comb begin
		logic [MAG_W+NM_W-1:0] wide;
		logic [MAG_W+NM_W-1:0] shifted;
		top_nx = (mag_s1[0] > mag_s1[1]) ? mag_s1[0] : mag_s1[1];
		if (mag_s1[2] > top_nx) top_nx = mag_s1[2];
		for (int i = 0; i < 3; i++) begin
			wide = {{NM_W{1'b0}}, mag_s3[i]};
			if (SH_W'(pos_s3) >= SH_W'(NORM_TOP_BIT)) begin
				shifted = wide >> (SH_W'(pos_s3) - SH_W'(NORM_TOP_BIT));
			end else begin
				shifted = wide << (SH_W'(NORM_TOP_BIT) - SH_W'(pos_s3));
			end
			m_nx[i] = shifted[NM_W-1:0];
		end
	end

	// One root bit per stage.
	always_comb begin
		logic [SQ_W-1:0] bitv;
		logic [SQ_W-1:0] trial;
		for (int k = 0; k < SQRT_STEPS; k++) begin
			bitv = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));
			trial = rt_res_s[k] + bitv;
			if (rt_rem_s[k] >= trial) begin
				rt_rem_nx[k] = rt_rem_s[k] - trial;
				rt_res_nx[k] = (rt_res_s[k] >> 1) + bitv;
			end else begin
				rt_rem_nx[k] = rt_rem_s[k];
				rt_res_nx[k] = rt_res_s[k] >> 1;
			end
		end
	end

	// One quotient bit per stage, most significant first.
	always_comb begin
		logic [DSOR_W-1:0] dsor;
		for (int j = 0; j < DIV_STEPS; j++) begin
			dsor = DSOR_W'(dv_len_s[j]) << (DIV_STEPS - 1 - j);
			for (int i = 0; i < 3; i++) begin
				dv_q_nx[j][i] = dv_q_s[j][i];
				if (DSOR_W'(dv_rem_s[j][i]) >= dsor) begin
					dv_rem_nx[j][i] = NUM_W'(DSOR_W'(dv_rem_s[j][i]) - dsor);
					dv_q_nx[j][i][DIV_STEPS-1-j] = 1'b1;
				end else begin
					dv_rem_nx[j][i] = dv_rem_s[j][i];
				end
			end
		end
	end

	// Front stages: magnitude, maximum, bit position, shift, squares.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= d[i][IN_W-1];
				mag_s1[i] <= d[i][IN_W-1] ? MAG_W'(-d[i]) : MAG_W'(d[i]);
				neg_s2[i] <= neg_s1[i];
				mag_s2[i] <= mag_s1[i];
				neg_s3[i] <= neg_s2[i];
				mag_s3[i] <= mag_s2[i];
				neg_s4[i] <= neg_s3[i];
				m_s4[i] <= m_nx[i];
				neg_s5[i] <= neg_s4[i];
				m_s5[i] <= m_s4[i];
				sq_s5[i] <= m_s4[i] * m_s4[i];
			end
			top_s2 <= top_nx;
			pos_s3 <= msb_pos(top_s2);
			zero_s3 <= (top_s2 == '0);
			zero_s4 <= zero_s3;
			zero_s5 <= zero_s4;
		end
	end

	// Square root stages.
	always_ff @(posedge clk) begin
		if (en) begin
			rt_rem_s[0] <= SQ_W'(sq_s5[0]) + SQ_W'(sq_s5[1]) + SQ_W'(sq_s5[2]);
			rt_res_s[0] <= '0;
			rt_zero_s[0] <= zero_s5;
			for (int i = 0; i < 3; i++) begin
				rt_m_s[0][i] <= m_s5[i];
				rt_neg_s[0][i] <= neg_s5[i];
			end
			for (int k = 0; k < SQRT_STEPS; k++) begin
				rt_rem_s[k+1] <= rt_rem_nx[k];
				rt_res_s[k+1] <= rt_res_nx[k];
				rt_zero_s[k+1] <= rt_zero_s[k];
				for (int i = 0; i < 3; i++) begin
					rt_m_s[k+1][i] <= rt_m_s[k][i];
					rt_neg_s[k+1][i] <= rt_neg_s[k][i];
				end
			end
		end
	end

	// Division stages and the signed result.
	always_ff @(posedge clk) begin
		if (en) begin
			dv_len_s[0] <= rt_res_s[SQRT_STEPS][ROOT_W-1:0];
			dv_zero_s[0] <= rt_zero_s[SQRT_STEPS];
			for (int i = 0; i < 3; i++) begin
				dv_rem_s[0][i] <= NUM_W'(rt_m_s[SQRT_STEPS][i]) << NORM_FRAC;
				dv_q_s[0][i] <= '0;
				dv_neg_s[0][i] <= rt_neg_s[SQRT_STEPS][i];
			end
			for (int j = 0; j < DIV_STEPS; j++) begin
				dv_len_s[j+1] <= dv_len_s[j];
				dv_zero_s[j+1] <= dv_zero_s[j];
				for (int i = 0; i < 3; i++) begin
					dv_rem_s[j+1][i] <= dv_rem_nx[j][i];
					dv_q_s[j+1][i] <= dv_q_nx[j][i];
					dv_neg_s[j+1][i] <= dv_neg_s[j][i];
				end
			end
			zero <= dv_zero_s[DIV_STEPS];
			for (int i = 0; i < 3; i++) begin
				if (dv_zero_s[DIV_STEPS]) begin
					u[i] <= '0;
				end else if (dv_neg_s[DIV_STEPS][i]) begin
					u[i] <= -$signed(NORM_W'(dv_q_s[DIV_STEPS][i]));
				end else begin
					u[i] <= $signed(NORM_W'(dv_q_s[DIV_STEPS][i]));
				end
			end
		end
	end
endmodule

FILE: src/bps_dot.sv
// Clamped dot product of the normal with a unit vector, two stages.
// Depends on bps_pkg.
module bps_dot #(
	parameter int COLOR_FRAC_BITS = bps_pkg::COLOR_FRAC_DEF
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [bps_pkg::NORM_W-1:0] n [3],
	input  logic signed [bps_pkg::NORM_W-1:0] u [3],
	output logic [COLOR_FRAC_BITS:0]          v
);
	import bps_pkg::*;

	localparam int CLR_W = COLOR_FRAC_BITS + 1;
	localparam int PRD_W = 2 * NORM_W;
	localparam int SUM_W = PRD_W + 2;
	localparam int SHIFT = 2 * NORM_FRAC - COLOR_FRAC_BITS;

	logic signed [PRD_W-1:0] prod_s1 [3];
	logic signed [SUM_W-1:0] sum;
	logic [SUM_W-1:0]        scaled;

	// Sum of products, then clamp below at zero and above at one.
	always_comb begin
		sum = SUM_W'(prod_s1[0]) + SUM_W'(prod_s1[1]) + SUM_W'(prod_s1[2]);
		scaled = $unsigned(sum) >> SHIFT;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_s1[i] <= PRD_W'(n[i]) * PRD_W'(u[i]);
			end
			if (sum <= 0) begin
				v <= '0;
			end else if (scaled > (SUM_W'(1) << COLOR_FRAC_BITS)) begin
				v <= CLR_W'(1) << COLOR_FRAC_BITS;
			end else begin
				v <= scaled[CLR_W-1:0];
			end
		end
	end
endmodule

FILE: src/bps_pow.sv
// Integer power by square-and-multiply, one exponent bit per stage.
// Depends on bps_pkg.
module bps_pow #(
	parameter int COLOR_FRAC_BITS = bps_pkg::COLOR_FRAC_DEF
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [COLOR_FRAC_BITS:0]     base,
	input  logic [bps_pkg::SHIN_W-1:0]   e,
	output logic [COLOR_FRAC_BITS:0]     acc
);
	import bps_pkg::*;

	localparam int CLR_W = COLOR_FRAC_BITS + 1;
	localparam int PRD_W = 2 * CLR_W;

	logic [CLR_W-1:0] pw_acc_s [SHIN_W];
	logic [CLR_W-1:0] pw_base_s [SHIN_W];
	logic [PRD_W-1:0] acc_prd [SHIN_W];
	logic [PRD_W-1:0] base_prd [SHIN_W];

	// Products of each stage; stage zero starts from one.
	always_comb begin
		acc_prd[0] = e[0] ? (PRD_W'(base) << COLOR_FRAC_BITS) : (PRD_W'(1) << (2 * COLOR_FRAC_BITS));
		base_prd[0] = PRD_W'(base) * PRD_W'(base);
		for (int k = 1; k < SHIN_W; k++) begin
			acc_prd[k] = e[k] ? PRD_W'(pw_acc_s[k-1]) * PRD_W'(pw_base_s[k-1])
				: PRD_W'(pw_acc_s[k-1]) << COLOR_FRAC_BITS;
			base_prd[k] = PRD_W'(pw_base_s[k-1]) * PRD_W'(pw_base_s[k-1]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < SHIN_W; k++) begin
				pw_acc_s[k] <= CLR_W'(acc_prd[k] >> COLOR_FRAC_BITS);
				pw_base_s[k] <= CLR_W'(base_prd[k] >> COLOR_FRAC_BITS);
			end
		end
	end

	assign acc = pw_acc_s[SHIN_W-1];
endmodule

FILE: src/blinn_phong_point_shader_top.sv
// Blinn-Phong point shader, top level: configuration registers, pipeline
// and output skid stage. Depends on bps_pkg, bps_norm, bps_dot, bps_pow, bps_delay.
//
// Use: items enter on in_valid/in_stall, one surface point each; one shaded
// colour leaves on out_valid/out_stall for every item, in order. An item is
// taken at a clock edge with valid high and stall low.
// Throughput is one item per cycle while in_stall is low. The pipeline holds
// two vector normalisers in series, each a 22-stage square root and a 15-stage
// divider, followed by the 8-stage shininess power.
// When out_stall holds a result, the pipeline moves one more item into a skid
// register and then freezes as a whole; in_stall is high exactly while the skid
// register is full. No item is lost or repeated.
// Registers sit on an APB-style port at byte address 8*index, 64 data bits,
// pready always high; they are to be written only while the block is idle.
// Reset (arst_n low) empties the pipeline and restores register defaults.
`include "blinn_phong_point_shader_top_macros.svh"

module blinn_phong_point_shader_top #(
	parameter int COORD_WIDTH = bps_pkg::COORD_WIDTH_DEF,
	parameter int COLOR_FRAC_BITS = bps_pkg::COLOR_FRAC_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bps_pkg::ADDR_W-1:0]    paddr,
	input  logic [bps_pkg::DATA_W-1:0]    pwdata,
	output logic [bps_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic signed [COORD_WIDTH-1:0] point_z,
	input  logic signed [bps_pkg::NORM_W-1:0] normal_x,
	input  logic signed [bps_pkg::NORM_W-1:0] normal_y,
	input  logic signed [bps_pkg::NORM_W-1:0] normal_z,
	input  logic [COLOR_FRAC_BITS:0]      material_red,
	input  logic [COLOR_FRAC_BITS:0]      material_green,
	input  logic [COLOR_FRAC_BITS:0]      material_blue,
	input  logic [COLOR_FRAC_BITS:0]      material_ambient,
	input  logic                          visible,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [COLOR_FRAC_BITS:0]      out_red,
	output logic [COLOR_FRAC_BITS:0]      out_green,
	output logic [COLOR_FRAC_BITS:0]      out_blue
);
	import bps_pkg::*;

	localparam int CLR_W = COLOR_FRAC_BITS + 1;
	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int POSF_W = 3 * COORD_WIDTH;
	localparam int LP_W = (POSF_W > DATA_W) ? DATA_W : POSF_W;
	localparam int LC_W = 3 * CLR_W;
	localparam int H_W = NORM_W + 1;
	localparam int N_PK_W = 3 * NORM_W;
	localparam int SB_W = 4 * CLR_W + 1;
	localparam int P_W = COLOR_FRAC_BITS + 2;
	localparam int K_W = COLOR_FRAC_BITS + 4;
	localparam int M_W = 2 * CLR_W;
	localparam int PR_W = P_W + K_W;
	localparam int F_W = PR_W - COLOR_FRAC_BITS;
	localparam int KD_DLY = 1 + NORM_LAT + POW_LAT;
	localparam int HZ_DLY = DOT_LAT + POW_LAT;
	localparam int SB_DLY = 1 + 2 * NORM_LAT + DOT_LAT + POW_LAT;
	localparam int PIPE_LAT = SB_DLY + 4;
	localparam logic [CLR_W-1:0] ONE = CLR_W'(1) << COLOR_FRAC_BITS;

	// Configuration registers.
	logic [LP_W-1:0]   lpos_q;
	logic [LP_W-1:0]   vpos_q;
	logic [LC_W-1:0]   lcol_q;
	logic [CLR_W-1:0]  lamb_q;
	logic [CLR_W-1:0]  ldiff_q;
	logic [CLR_W-1:0]  lspec_q;
	logic [SHIN_W-1:0] shin_q;
	logic [IDX_W-1:0]  reg_idx;

	// Pipeline control.
	logic                en;
	logic                vld_s [PIPE_LAT];
	logic                skid_q;
	logic                out_valid_q;
	logic                out_take;
	logic [CLR_W-1:0]    col_q [3];
	logic [CLR_W-1:0]    skid_col_q [3];
	logic [CLR_W-1:0]    col_nx [3];

	// Datapath.
	logic [POSF_W-1:0]         lpos_x;
	logic [POSF_W-1:0]         vpos_x;
	logic signed [COORD_WIDTH-1:0] pt [3];
	logic signed [DIFF_W-1:0]  dl_nx [3];
	logic signed [DIFF_W-1:0]  dv_nx [3];
	logic signed [DIFF_W-1:0]  dl_s1 [3];
	logic signed [DIFF_W-1:0]  dv_s1 [3];
	logic [N_PK_W-1:0]         n_s1;
	logic [SB_W-1:0]           sb_s1;
	logic signed [NORM_W-1:0]  ul [3];
	logic signed [NORM_W-1:0]  uv [3];
	logic                      lzero;
	logic                      vzero;
	logic [N_PK_W-1:0]         n_a_pk;
	logic [N_PK_W-1:0]         n_b_pk;
	logic signed [NORM_W-1:0]  n_a [3];
	logic signed [NORM_W-1:0]  n_b [3];
	logic signed [H_W-1:0]     h_s [3];
	logic signed [NORM_W-1:0]  uh [3];
	logic                      hzero;
	logic [CLR_W-1:0]          kd;
	logic [CLR_W-1:0]          kd_k;
	logic [CLR_W-1:0]          dh;
	logic [CLR_W-1:0]          ks_raw;
	logic                      hz_k;
	logic [CLR_W-1:0]          ks;
	logic [SB_W-1:0]           sb_k;
	logic [P_W-1:0]            mclc_s1f [3];
	logic [P_W-1:0]            pamb_s1f;
	logic [P_W-1:0]            pd_s1f;
	logic [P_W-1:0]            ps_s1f;
	logic                      vis_s1f;
	logic [P_W-1:0]            mclc_s2f [3];
	logic [K_W-1:0]            k_s2f;
	logic [F_W-1:0]            f_s3f [3];

	assign pready = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:ADDR_W-IDX_W];

	// Register writes on the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lpos_q <= '0;
			vpos_q <= '0;
			lcol_q <= '0;
			lamb_q <= '0;
			ldiff_q <= ONE;
			lspec_q <= ONE;
			shin_q <= SHIN_W'(SHIN_RESET);
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_LIGHT_POS:  lpos_q <= pwdata[LP_W-1:0];
				REG_VIEW_POS:   vpos_q <= pwdata[LP_W-1:0];
				REG_LIGHT_COL:  lcol_q <= pwdata[LC_W-1:0];
				REG_LIGHT_AMB:  lamb_q <= pwdata[CLR_W-1:0];
				REG_LIGHT_DIFF: ldiff_q <= pwdata[CLR_W-1:0];
				REG_LIGHT_SPEC: lspec_q <= pwdata[CLR_W-1:0];
				REG_SHININESS:  shin_q <= pwdata[SHIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Register reads.
	always_comb begin
		case (reg_idx)
			REG_LIGHT_POS:  prdata = DATA_W'(lpos_q);
			REG_VIEW_POS:   prdata = DATA_W'(vpos_q);
			REG_LIGHT_COL:  prdata = DATA_W'(lcol_q);
			REG_LIGHT_AMB:  prdata = DATA_W'(lamb_q);
			REG_LIGHT_DIFF: prdata = DATA_W'(ldiff_q);
			REG_LIGHT_SPEC: prdata = DATA_W'(lspec_q);
			REG_SHININESS:  prdata = DATA_W'(shin_q);
			default:        prdata = '0;
		endcase
	end

	// The whole pipeline moves unless the skid register is holding an item.
	assign en = !skid_q;
	assign in_stall = skid_q;

	// Directions from the point to the light and to the eye.
	always_comb begin
		lpos_x = POSF_W'(lpos_q);
		vpos_x = POSF_W'(vpos_q);
		pt[0] = point_x;
		pt[1] = point_y;
		pt[2] = point_z;
		for (int i = 0; i < 3; i++) begin
			dl_nx[i] = DIFF_W'($signed(lpos_x[i*COORD_WIDTH +: COORD_WIDTH])) - DIFF_W'(pt[i]);
			dv_nx[i] = DIFF_W'($signed(vpos_x[i*COORD_WIDTH +: COORD_WIDTH])) - DIFF_W'(pt[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dl_s1[i] <= dl_nx[i];
				dv_s1[i] <= dv_nx[i];
			end
			n_s1 <= {normal_z, normal_y, normal_x};
			sb_s1 <= {visible, material_ambient, material_blue, material_green, material_red};
		end
	end

	bps_norm #(.IN_W(DIFF_W)) u_norm_l (
		.clk(clk), .en(en), .d(dl_s1), .u(ul), .zero(lzero)
	);

	bps_norm #(.IN_W(DIFF_W)) u_norm_v (
		.clk(clk), .en(en), .d(dv_s1), .u(uv), .zero(vzero)
	);

	bps_delay #(.W(N_PK_W), .N(NORM_LAT)) u_dly_n_a (
		.clk(clk), .en(en), .din(n_s1), .dout(n_a_pk)
	);

	bps_delay #(.W(N_PK_W), .N(NORM_LAT + 1)) u_dly_n_b (
		.clk(clk), .en(en), .din(n_a_pk), .dout(n_b_pk)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			n_a[i] = $signed(n_a_pk[i*NORM_W +: NORM_W]);
			n_b[i] = $signed(n_b_pk[i*NORM_W +: NORM_W]);
		end
	end

	// Diffuse factor.
	bps_dot #(.COLOR_FRAC_BITS(COLOR_FRAC_BITS)) u_dot_l (
		.clk(clk), .en(en), .n(n_a), .u(ul), .v(kd)
	);

	// Halfway vector; a zero unit vector drops out of the sum.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				h_s[i] <= (lzero ? H_W'(0) : H_W'(ul[i])) + (vzero ? H_W'(0) : H_W'(uv[i]));
			end
		end
	end

	bps_norm #(.IN_W(H_W)) u_norm_h (
		.clk(clk), .en(en), .d(h_s), .u(uh), .zero(hzero)
	);

	bps_dot #(.COLOR_FRAC_BITS(COLOR_FRAC_BITS)) u_dot_h (
		.clk(clk), .en(en), .n(n_b), .u(uh), .v(dh)
	);

	bps_pow #(.COLOR_FRAC_BITS(COLOR_FRAC_BITS)) u_pow (
		.clk(clk), .en(en), .base(dh), .e(shin_q), .acc(ks_raw)
	);

	bps_delay #(.W(1), .N(HZ_DLY)) u_dly_hz (
		.clk(clk), .en(en), .din(hzero), .dout(hz_k)
	);

	bps_delay #(.W(CLR_W), .N(KD_DLY)) u_dly_kd (
		.clk(clk), .en(en), .din(kd), .dout(kd_k)
	);

	bps_delay #(.W(SB_W), .N(SB_DLY)) u_dly_sb (
		.clk(clk), .en(en), .din(sb_s1), .dout(sb_k)
	);

	// A zero halfway vector gives no specular term.
	assign ks = hz_k ? '0 : ks_raw;

	// Colour stages: products, strength sum, final scale.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mclc_s1f[i] <= P_W'((M_W'(sb_k[i*CLR_W +: CLR_W]) * M_W'(lcol_q[i*CLR_W +: CLR_W]))
					>> COLOR_FRAC_BITS);
				mclc_s2f[i] <= mclc_s1f[i];
				f_s3f[i] <= F_W'((PR_W'(mclc_s2f[i]) * PR_W'(k_s2f)) >> COLOR_FRAC_BITS);
			end
			pamb_s1f <= P_W'((M_W'(sb_k[3*CLR_W +: CLR_W]) * M_W'(lamb_q)) >> COLOR_FRAC_BITS);
			pd_s1f <= P_W'((M_W'(kd_k) * M_W'(ldiff_q)) >> COLOR_FRAC_BITS);
			ps_s1f <= P_W'((M_W'(ks) * M_W'(lspec_q)) >> COLOR_FRAC_BITS);
			vis_s1f <= sb_k[SB_W-1];
			k_s2f <= K_W'(pamb_s1f) + (vis_s1f ? (K_W'(pd_s1f) + K_W'(ps_s1f)) : K_W'(0));
		end
	end

	// Saturate at one.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			col_nx[i] = (f_s3f[i] > F_W'(ONE)) ? ONE : f_s3f[i][CLR_W-1:0];
		end
	end

	// Valid bits beside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PIPE_LAT; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < PIPE_LAT; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// Output register with a skid register behind it.
	assign out_take = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_q <= 1'b0;
		end else begin
			if (en && vld_s[PIPE_LAT-1]) begin
				if (!out_valid_q || out_take) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_q <= 1'b1;
				end
			end else if (skid_q && out_take) begin
				skid_q <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld_s[PIPE_LAT-1]) begin
			if (!out_valid_q || out_take) begin
				col_q <= col_nx;
			end else begin
				skid_col_q <= col_nx;
			end
		end else if (skid_q && out_take) begin
			col_q <= skid_col_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_red = col_q[0];
	assign out_green = col_q[1];
	assign out_blue = col_q[2];

	// The skid register only fills behind a held output.
	`BPS_ASSERT_SAME(a_skid_has_out, skid_q, out_valid_q)
	`BPS_ASSERT_NEXT(a_skid_fills, (!skid_q && vld_s[PIPE_LAT-1] && out_valid_q && out_stall), skid_q)
	`BPS_ASSERT_SAME(a_out_saturated, out_valid_q, (out_red <= ONE) && (out_green <= ONE) && (out_blue <= ONE))
endmodule
